FILE: sv/assert_macros.svh
// Assertion macros shared by the RTL of the frame decoder.
// No dependencies; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, held off during reset.
`define ASSERT_IMPLIES(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("assertion failed: same-cycle implication");

// Next-cycle implication, held off during reset.
`define ASSERT_NEXT(label, clk, rst, ante, cons) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("assertion failed: next-cycle implication");

`endif

FILE: sv/ctxhf_pkg.sv
// Types, constants and the character set of the context Huffman frame decoder.
// No dependencies.
`timescale 1ns / 1ps

package ctxhf_pkg;

  localparam int SYM_W  = 3;
  localparam int CHAR_W = 8;
  localparam int CNT_W  = 8;

  typedef enum logic [1:0] {
    PH_TABLE,
    PH_TREE,
    PH_CODE
  } phase_t;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_DIV,
    ST_PICK,
    ST_WALK,
    ST_LEAF,
    ST_FLUSH
  } state_t;

  typedef struct packed {
    logic [CHAR_W-1:0] char_code;
    logic [SYM_W-1:0]  symbol_index;
    logic              end_of_line;
    logic              end_of_frame;
    logic              tree_error;
  } result_t;

  // register index, taken from paddr[2]
  localparam logic REG_COLUMNS = 1'b0;
  localparam logic REG_LINES   = 1'b1;

  localparam logic [CNT_W-1:0] COLUMNS_RESET = 8'd80;
  localparam logic [CNT_W-1:0] LINES_RESET   = 8'd22;

  function automatic logic [CHAR_W-1:0] glyph(input logic [SYM_W-1:0] sym);
    logic [CHAR_W-1:0] ch;
    case (sym)
      3'd0:    ch = 8'h20;  // ' '
      3'd1:    ch = 8'h2C;  // ','
      3'd2:    ch = 8'h28;  // '('
      3'd3:    ch = 8'h53;  // 'S'
      3'd4:    ch = 8'h23;  // '#'
      3'd5:    ch = 8'h67;  // 'g'
      3'd6:    ch = 8'h40;  // '@'
      default: ch = 8'h2E;  // '.'
    endcase
    return ch;
  endfunction

endpackage

FILE: sv/context_huffman_frame_decoder_top.sv
// Context Huffman frame decoder: table loader, tree loader and bit-serial walker.
// Depends on ctxhf_pkg and assert_macros.svh.
// A table byte or a tree byte is taken in the idle state; the second byte of a table word
// then runs, for each rank entry in turn, a 16-step radix divider and one pick. A code byte
// takes an accept, one walk step per code bit, one leaf state per leaf for the rank read and
// a flush, stretched by output stalls.
// Reset (rst, synchronous) clears control state; tables stay undefined until loaded.
`timescale 1ns / 1ps
`include "assert_macros.svh"

module context_huffman_frame_decoder_top #(
  parameter int SYMBOL_COUNT = 7
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            psel,
  input  logic                            penable,
  input  logic                            pwrite,
  input  logic [2:0]                      paddr,
  input  logic [31:0]                     pwdata,
  output logic [31:0]                     prdata,
  output logic                            pready,
  input  logic                            in_valid,
  output logic                            in_ready,
  input  logic [7:0]                      data_byte,
  output logic                            out_valid,
  input  logic                            out_ready,
  output logic [ctxhf_pkg::CHAR_W-1:0]    char_code,
  output logic [ctxhf_pkg::SYM_W-1:0]     symbol_index,
  output logic                            end_of_line,
  output logic                            end_of_frame,
  output logic                            tree_error,
  output logic                            last_of_run
);
  import ctxhf_pkg::*;

  localparam int NODE_IW = (SYMBOL_COUNT > 2) ? $clog2(SYMBOL_COUNT - 1) : 1;
  localparam int DIG_W   = $clog2(SYMBOL_COUNT);
  localparam int ADDR_W  = $clog2(SYMBOL_COUNT * SYMBOL_COUNT);
  localparam int DEPTH   = SYMBOL_COUNT * SYMBOL_COUNT;
  localparam logic [3:0] SYM_BASE = 4'(SYMBOL_COUNT);
  localparam logic [3:0] ROOT     = 4'(2 * SYMBOL_COUNT - 2);
  localparam logic [ADDR_W-1:0] LAST_ADDR = ADDR_W'(DEPTH - 1);
  localparam logic [DIG_W-1:0]  LAST_DIG  = DIG_W'(SYMBOL_COUNT - 1);
  localparam logic [NODE_IW-1:0] LAST_TREE = NODE_IW'(SYMBOL_COUNT - 2);

  state_t state, state_next;
  phase_t phase;

  // configuration
  logic [CNT_W-1:0] cols_reg, lines_reg;

  // table loading
  logic             held_valid;
  logic [7:0]       held_byte;
  logic [15:0]      div;
  logic [SYM_W-1:0] rem;
  logic [3:0]       div_cnt;
  logic [DIG_W-1:0] digit;
  logic [ADDR_W-1:0] wr_addr;
  logic [SYM_W-1:0] pool [SYMBOL_COUNT];
  logic [NODE_IW-1:0] tree_cnt;
  logic [3:0]       left_ch  [SYMBOL_COUNT-1];
  logic [3:0]       right_ch [SYMBOL_COUNT-1];

  // rank table memory
  logic [SYM_W-1:0]  rank_mem [DEPTH];
  logic [SYM_W-1:0]  rank_q;
  logic [ADDR_W-1:0] rank_rd_addr;
  logic              rank_we;

  // walk
  logic [7:0]       code_sr;
  logic [3:0]       bits_left;
  logic [3:0]       pos;
  logic [SYM_W-1:0] prev;
  logic [CNT_W-1:0] col, line;

  // results: one pending, one in the output register
  logic    pend_valid;
  result_t pend_res;
  result_t out_res;
  logic    out_last;

  // combinational
  logic               acc, out_free;
  logic [3:0]         node_off, child, radix, t_div;
  logic [NODE_IW-1:0] node_idx;
  logic               child_err, child_leaf, div_ge;
  logic [DIG_W-1:0]   pick;
  logic               col_hit, line_hit, leaf_eof;
  logic               res_push, flush_push;
  result_t            res_new;
  logic               cfg_we;

  assign pready = 1'b1;
  assign cfg_we = psel & penable & pwrite & pready;
  assign prdata = {24'd0, (paddr[2] == REG_LINES) ? lines_reg : cols_reg};

  assign char_code    = out_res.char_code;
  assign symbol_index = out_res.symbol_index;
  assign end_of_line  = out_res.end_of_line;
  assign end_of_frame = out_res.end_of_frame;
  assign tree_error   = out_res.tree_error;
  assign last_of_run  = out_last;

  always_comb begin
    state_next = state;
    in_ready   = (state == ST_IDLE);
    acc        = in_valid & in_ready;
    out_free   = !out_valid || out_ready;

    node_off   = pos - SYM_BASE;
    node_idx   = node_off[NODE_IW-1:0];
    child      = code_sr[7] ? right_ch[node_idx] : left_ch[node_idx];
    child_err  = (child > ROOT);
    child_leaf = (child < SYM_BASE);
    rank_rd_addr = ADDR_W'(int'(prev) * SYMBOL_COUNT + int'(child));

    radix  = SYM_BASE - 4'(digit);
    t_div  = {rem, div[15]};
    div_ge = (t_div >= radix);
    pick   = rem[DIG_W-1:0];
    rank_we = (state == ST_PICK);

    col_hit  = ({1'b0, col} + 9'd1) >= {1'b0, cols_reg};
    line_hit = ({1'b0, line} + 9'd1) >= {1'b0, lines_reg};
    leaf_eof = col_hit && line_hit;

    res_push   = 1'b0;
    flush_push = 1'b0;
    res_new    = '0;

    case (state)
      ST_IDLE: begin
        if (acc) begin
          case (phase)
            PH_CODE: state_next = ST_WALK;
            PH_TREE: state_next = ST_IDLE;
            default: if (held_valid) state_next = ST_DIV;
          endcase
        end
      end
      ST_DIV: begin
        if (div_cnt == 4'd15) state_next = ST_PICK;
      end
      ST_PICK: begin
        state_next = (digit == LAST_DIG) ? ST_IDLE : ST_DIV;
      end
      ST_WALK: begin
        if (out_free) begin
          if (child_err) begin
            res_push           = 1'b1;
            res_new.tree_error = 1'b1;
            state_next = (bits_left == 4'd1) ? ST_FLUSH : ST_WALK;
          end else if (child_leaf) begin
            state_next = ST_LEAF;
          end else begin
            state_next = (bits_left == 4'd1) ? ST_FLUSH : ST_WALK;
          end
        end
      end
      ST_LEAF: begin
        if (out_free) begin
          res_push             = 1'b1;
          res_new.char_code    = glyph(rank_q);
          res_new.symbol_index = rank_q;
          res_new.end_of_line  = col_hit;
          res_new.end_of_frame = leaf_eof;
          // drop the rest of the byte at frame end
          state_next = (leaf_eof || bits_left == 4'd0) ? ST_FLUSH : ST_WALK;
        end
      end
      ST_FLUSH: begin
        if (!pend_valid) begin
          state_next = ST_IDLE;
        end else if (out_free) begin
          flush_push = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) state <= ST_IDLE;
    else     state <= state_next;
  end

  always_ff @(posedge clk) begin
    if (rank_we) rank_mem[wr_addr] <= pool[pick];
    // hold the read symbol while a leaf waits on the output
    if (state == ST_WALK) rank_q <= rank_mem[rank_rd_addr];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      cols_reg   <= COLUMNS_RESET;
      lines_reg  <= LINES_RESET;
      phase      <= PH_TABLE;
      held_valid <= 1'b0;
      tree_cnt   <= '0;
      wr_addr    <= '0;
      digit      <= '0;
      div_cnt    <= '0;
      bits_left  <= '0;
      pos        <= ROOT;
      prev       <= '0;
      col        <= '0;
      line       <= '0;
      pend_valid <= 1'b0;
      out_valid  <= 1'b0;
    end else begin
      if (cfg_we) begin
        if (paddr[2] == REG_LINES) lines_reg <= pwdata[CNT_W-1:0];
        else                       cols_reg  <= pwdata[CNT_W-1:0];
      end

      case (state)
        ST_IDLE: begin
          if (acc) begin
            case (phase)
              PH_CODE: begin
                code_sr   <= data_byte;
                bits_left <= 4'd8;
              end
              PH_TREE: begin
                left_ch[tree_cnt]  <= data_byte[7:4];
                right_ch[tree_cnt] <= data_byte[3:0];
                if (tree_cnt == LAST_TREE) begin
                  tree_cnt <= '0;
                  phase    <= PH_CODE;
                  pos      <= ROOT;
                  prev     <= '0;
                  col      <= '0;
                  line     <= '0;
                end else begin
                  tree_cnt <= tree_cnt + 1'b1;
                end
              end
              default: begin
                if (!held_valid) begin
                  held_valid <= 1'b1;
                  held_byte  <= data_byte;
                end else begin
                  held_valid <= 1'b0;
                  div        <= {held_byte, data_byte};
                  rem        <= '0;
                  div_cnt    <= '0;
                  digit      <= '0;
                  for (int j = 0; j < SYMBOL_COUNT; j++) pool[j] <= SYM_W'(j);
                end
              end
            endcase
          end
        end
        ST_DIV: begin
          // one quotient bit per cycle
          rem     <= div_ge ? SYM_W'(t_div - radix) : t_div[SYM_W-1:0];
          div     <= {div[14:0], div_ge};
          div_cnt <= div_cnt + 4'd1;
        end
        ST_PICK: begin
          // remove the picked entry from the pool
          for (int j = 0; j < SYMBOL_COUNT - 1; j++) begin
            if (j >= int'(pick)) pool[j] <= pool[j+1];
          end
          rem     <= '0;
          div_cnt <= '0;
          if (wr_addr == LAST_ADDR) begin
            wr_addr <= '0;
            phase   <= PH_TREE;
          end else begin
            wr_addr <= wr_addr + 1'b1;
          end
          if (digit == LAST_DIG) digit <= '0;
          else                   digit <= digit + 1'b1;
        end
        ST_WALK: begin
          if (out_free) begin
            code_sr   <= {code_sr[6:0], 1'b0};
            bits_left <= bits_left - 4'd1;
            if (child_err || child_leaf) pos <= ROOT;
            else                         pos <= child;
          end
        end
        ST_LEAF: begin
          if (out_free) begin
            prev <= rank_q;
            pos  <= ROOT;
            if (col_hit) begin
              col <= '0;
              if (!line_hit) line <= line + 1'b1;
            end else begin
              col <= col + 1'b1;
            end
            if (leaf_eof) begin
              prev       <= '0;
              line       <= '0;
              phase      <= PH_TABLE;
              wr_addr    <= '0;
              digit      <= '0;
              held_valid <= 1'b0;
            end
          end
        end
        default: ;
      endcase

      // advance the pending result into the output register
      if (res_push) begin
        pend_valid <= 1'b1;
        pend_res   <= res_new;
        if (pend_valid) begin
          out_valid <= 1'b1;
          out_res   <= pend_res;
          out_last  <= 1'b0;
        end else if (out_ready) begin
          out_valid <= 1'b0;
        end
      end else if (flush_push) begin
        pend_valid <= 1'b0;
        out_valid  <= 1'b1;
        out_res    <= pend_res;
        out_last   <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  `ASSERT_IMPLIES(a_idle_no_pending, clk, rst, state == ST_IDLE, !pend_valid)
  `ASSERT_IMPLIES(a_walk_has_bits, clk, rst, state == ST_WALK, bits_left != 4'd0)
  `ASSERT_IMPLIES(a_eof_is_last, clk, rst, out_valid && end_of_frame, end_of_line && last_of_run)
  `ASSERT_IMPLIES(a_err_blank, clk, rst, out_valid && tree_error, char_code == 8'd0 && !end_of_line)
  `ASSERT_NEXT(a_eof_reloads, clk, rst, state == ST_LEAF && out_free && leaf_eof, phase == PH_TABLE && !held_valid)

endmodule

FILE: dv/testbench.sv
// Self-checking testbench for context_huffman_frame_decoder_top: frames of rank-table words,
// tree bytes and code bits go in under random stalls, decoded characters are checked.
// Depends on ctxhf_pkg and the decoder RTL.
`timescale 1ns / 1ps

module testbench;
  import ctxhf_pkg::*;

  localparam int SYMS        = 7;
  localparam int ROOT        = 2 * SYMS - 2;
  localparam int IDLE_WAIT   = 200;
  localparam int STALL_LIMIT = 3000;

  // ' ' ',' '(' 'S' '#' 'g' '@' '.'
  localparam logic [7:0] CHARSET [8] = '{8'h20, 8'h2C, 8'h28, 8'h53, 8'h23, 8'h67, 8'h40, 8'h2E};

  // Seven words: zero, all ones, both sides of 7!, and a few more; then a tree whose
  // node 10 has a bad right child (node 9 left dangling); then code bytes.
  localparam logic [7:0] OPENING_FRAME [23] = '{
    8'h00, 8'h00, 8'hFF, 8'hFF, 8'h13, 8'hAF, 8'h13, 8'hB0, 8'h80, 8'h00, 8'h00, 8'h01,
    8'h7F, 8'hFF, 8'h01, 8'h23, 8'h45, 8'h6D, 8'h78, 8'hBA, 8'h00, 8'hFF, 8'h5A};

  localparam logic [7:0] COLUMN_PLAN [8] = '{8'd1, 8'd255, 8'd3, 8'd255, 8'd1, 8'd7, 8'd2, 8'd12};
  localparam logic [7:0] LINE_PLAN   [8] = '{8'd1, 8'd255, 8'd2, 8'd1, 8'd255, 8'd3, 8'd2, 8'd4};

  typedef struct packed {
    phase_t           ph;
    logic [2:0]       row;
    logic             held_v;
    logic [7:0]       held;
    logic [2:0]       tree_n;
    logic [48:0][2:0] rank;
    logic [5:0][3:0]  lch;
    logic [5:0][3:0]  rch;
    logic [3:0]       node;
    logic [2:0]       prev;
    logic [7:0]       col;
    logic [7:0]       line;
    logic [7:0]       cols_cfg;
    logic [7:0]       lines_cfg;
  } decoder_t;

  typedef struct packed {
    result_t res;
    logic    last_of_run;
  } char_word_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        psel = 1'b0;
  logic        penable = 1'b0;
  logic        pwrite = 1'b0;
  logic [2:0]  paddr = '0;
  logic [31:0] pwdata = '0;
  logic [31:0] prdata;
  logic        pready;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic [7:0]  data_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [7:0]  char_code;
  logic [2:0]  symbol_index;
  logic        end_of_line;
  logic        end_of_frame;
  logic        tree_error;
  logic        last_of_run;

  decoder_t    chk;          // advanced on accepted words
  decoder_t    gen;          // advanced as words are queued, to shape the stream
  logic [7:0]  stream_bytes [$];
  char_word_t  decoded_words [$];
  char_word_t  want;
  logic [7:0]  tree_plan [6];
  logic [7:0]  word_low;
  int          mismatches = 0;
  int          stall_cycles = 0;
  int          in_idle = 0, in_busy = 0, out_idle = 0, out_busy = 0;
  bit          quiet_tail = 1'b0;

  context_huffman_frame_decoder_top u_top (
    .clk(clk), .rst(rst),
    .psel(psel), .penable(penable), .pwrite(pwrite), .paddr(paddr), .pwdata(pwdata),
    .prdata(prdata), .pready(pready),
    .in_valid(in_valid), .in_ready(in_ready), .data_byte(data_byte),
    .out_valid(out_valid), .out_ready(out_ready),
    .char_code(char_code), .symbol_index(symbol_index), .end_of_line(end_of_line),
    .end_of_frame(end_of_frame), .tree_error(tree_error), .last_of_run(last_of_run)
  );

  always #1 clk = ~clk;

  function automatic void decode_byte(inout decoder_t s, input logic [7:0] b,
                                      ref char_word_t words[$]);
    logic [6:0][2:0] pool;
    int unsigned     w, radix, pick;
    logic [3:0]      node, child;
    logic [2:0]      sym;
    char_word_t      e;
    int              produced;
    bit              done;
    produced = 0;
    done = 1'b0;
    case (s.ph)
      PH_TREE: begin
        s.lch[s.tree_n] = b[7:4];
        s.rch[s.tree_n] = b[3:0];
        if (s.tree_n == SYMS - 2) begin
          s.tree_n = '0;
          s.ph = PH_CODE;
          s.node = 4'(ROOT);
          s.prev = '0;
          s.col = '0;
          s.line = '0;
        end else begin
          s.tree_n++;
        end
      end
      PH_CODE: begin
        for (int i = 7; i >= 0 && !done; i--) begin
          node = (s.node < SYMS || s.node > ROOT) ? 4'(ROOT) : s.node;
          child = b[i] ? s.rch[node - SYMS] : s.lch[node - SYMS];
          e = '0;
          if (child > ROOT) begin
            e.res.tree_error = 1'b1;
            words.push_back(e);
            produced++;
            s.node = 4'(ROOT);
          end else if (child < SYMS) begin
            sym = s.rank[s.prev * SYMS + child];
            s.prev = sym;
            s.node = 4'(ROOT);
            e.res.char_code = CHARSET[sym];
            e.res.symbol_index = sym;
            if (int'(s.col) + 1 >= int'(s.cols_cfg)) begin
              s.col = '0;
              e.res.end_of_line = 1'b1;
              if (int'(s.line) + 1 >= int'(s.lines_cfg)) e.res.end_of_frame = 1'b1;
              else s.line++;
            end else begin
              s.col++;
            end
            words.push_back(e);
            produced++;
            // frame done: drop the rest of the byte and go back to table loading
            if (e.res.end_of_frame) begin
              s.ph = PH_TABLE;
              s.row = '0;
              s.held_v = 1'b0;
              s.node = 4'(ROOT);
              s.prev = '0;
              s.col = '0;
              s.line = '0;
              done = 1'b1;
            end
          end else begin
            s.node = child;
          end
        end
        if (produced > 0) words[words.size() - 1].last_of_run = 1'b1;
      end
      default: begin
        if (!s.held_v) begin
          s.held_v = 1'b1;
          s.held = b;
        end else begin
          w = {16'd0, s.held, b};
          s.held_v = 1'b0;
          for (int j = 0; j < SYMS; j++) pool[j] = 3'(j);
          // mixed-radix digits pick from the shrinking pool; high leftover is ignored
          for (int i = 0; i < SYMS; i++) begin
            radix = SYMS - i;
            pick = w % radix;
            w = w / radix;
            s.rank[s.row * SYMS + i] = pool[pick];
            for (int j = pick; j < SYMS - 1; j++) pool[j] = pool[j + 1];
          end
          if (s.row == SYMS - 1) begin
            s.row = '0;
            s.ph = PH_TREE;
          end else begin
            s.row++;
          end
        end
      end
    endcase
  endfunction

  function automatic bit take_break(inout int idle_left, inout int busy_left);
    if (quiet_tail) begin
      idle_left = 0;
      return 1'b0;
    end
    if (idle_left > 0) begin
      idle_left--;
      return 1'b1;
    end
    if (busy_left > 0) begin
      busy_left--;
    end else begin
      idle_left = $urandom_range(1, 12);
      busy_left = ($urandom_range(0, 5) == 0) ? $urandom_range(40, 150) : $urandom_range(0, 12);
    end
    return 1'b0;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int expected);
    $display("MISMATCH %s: got %0d, expected %0d", what, got, expected);
    mismatches++;
  endtask

  task automatic queue_byte(input logic [7:0] b);
    char_word_t discard [$];
    stream_bytes.push_back(b);
    decode_byte(gen, b, discard);
  endtask

  // Shape the stream from the lookahead state: words, then a tree, then code bytes.
  task automatic gen_phase(input int count);
    logic [3:0]  avail [$];
    logic [3:0]  a, c;
    logic [15:0] word;
    logic [7:0]  b;
    int          k;
    repeat (count) begin
      case (gen.ph)
        PH_TREE: begin
          if (gen.tree_n == 0) begin
            avail.delete();
            for (int n = 0; n < SYMS; n++) avail.push_back(4'(n));
            for (int n = SYMS; n <= ROOT; n++) begin
              k = $urandom_range(0, avail.size() - 1);
              a = avail[k];
              avail.delete(k);
              k = $urandom_range(0, avail.size() - 1);
              c = avail[k];
              avail.delete(k);
              avail.push_back(4'(n));
              tree_plan[n - SYMS] = {a, c};
            end
            // break one child now and then: bad index, loop or stray leaf
            if ($urandom_range(0, 4) == 0) begin
              k = $urandom_range(0, SYMS - 2);
              if ($urandom_range(0, 1)) tree_plan[k][7:4] = 4'($urandom_range(0, 15));
              else tree_plan[k][3:0] = 4'($urandom_range(0, 15));
            end
          end
          b = tree_plan[gen.tree_n];
        end
        PH_CODE: begin
          case ($urandom_range(0, 15))
            0:       b = 8'h00;
            1:       b = 8'hFF;
            default: b = 8'($urandom_range(0, 255));
          endcase
        end
        default: begin
          if (!gen.held_v) begin
            word = $urandom_range(0, 1) ? 16'($urandom_range(0, 5039))
                                        : 16'($urandom_range(0, 65535));
            b = word[15:8];
            word_low = word[7:0];
          end else begin
            b = word_low;
          end
        end
      endcase
      queue_byte(b);
    end
  endtask

  // Wait until every word is in and decoded, then let any silent work finish.
  task automatic settle();
    while (stream_bytes.size() > 0 || in_valid || decoded_words.size() > 0) @(negedge clk);
    repeat (IDLE_WAIT) @(negedge clk);
  endtask

  task automatic write_reg(input logic idx, input logic [7:0] value);
    @(posedge clk);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= {24'd0, value};
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    pwrite <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    if (prdata[7:0] !== value)
      report_mismatch("register read-back", int'(prdata[7:0]), int'(value));
    psel <= 1'b0;
    penable <= 1'b0;
    if (idx == REG_COLUMNS) begin
      chk.cols_cfg = value;
      gen.cols_cfg = value;
    end else begin
      chk.lines_cfg = value;
      gen.lines_cfg = value;
    end
  endtask

  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && in_ready) decode_byte(chk, data_byte, decoded_words);
      // hold the word until it is taken
      if (!in_valid || in_ready) begin
        if (!take_break(in_idle, in_busy) && stream_bytes.size() > 0) begin
          in_valid <= 1'b1;
          data_byte <= stream_bytes.pop_front();
        end else begin
          in_valid <= 1'b0;
        end
      end
    end
  end

  always @(posedge clk) begin
    if (rst) begin
      out_ready <= 1'b0;
    end else begin
      if (out_valid && out_ready) begin
        if (decoded_words.size() == 0) begin
          report_mismatch("word with nothing pending, char_code", int'(char_code), 0);
        end else begin
          want = decoded_words.pop_front();
          if (char_code !== want.res.char_code)
            report_mismatch("char_code", int'(char_code), int'(want.res.char_code));
          if (symbol_index !== want.res.symbol_index)
            report_mismatch("symbol_index", int'(symbol_index), int'(want.res.symbol_index));
          if (end_of_line !== want.res.end_of_line)
            report_mismatch("end_of_line", int'(end_of_line), int'(want.res.end_of_line));
          if (end_of_frame !== want.res.end_of_frame)
            report_mismatch("end_of_frame", int'(end_of_frame), int'(want.res.end_of_frame));
          if (tree_error !== want.res.tree_error)
            report_mismatch("tree_error", int'(tree_error), int'(want.res.tree_error));
          if (last_of_run !== want.last_of_run)
            report_mismatch("last_of_run", int'(last_of_run), int'(want.last_of_run));
        end
      end
      out_ready <= !take_break(out_idle, out_busy);
    end
  end

  always @(posedge clk) begin
    if ((in_valid && in_ready) || (out_valid && out_ready) || (psel && penable))
      stall_cycles <= 0;
    else
      stall_cycles <= stall_cycles + 1;
  end

  initial begin
    while (stall_cycles < STALL_LIMIT) @(posedge clk);
    $display("Some tests failed");
    $finish;
  end

  initial begin
    chk = '0;
    chk.ph = PH_TABLE;
    chk.node = 4'(ROOT);
    chk.cols_cfg = COLUMNS_RESET;
    chk.lines_cfg = LINES_RESET;
    gen = chk;
    repeat (12) @(posedge clk);
    rst <= 1'b0;
    @(negedge clk);
    foreach (OPENING_FRAME[i]) queue_byte(OPENING_FRAME[i]);
    settle();
    // zero counts: every character closes its line and the frame
    write_reg(REG_COLUMNS, 8'd0);
    write_reg(REG_LINES, 8'd0);
    gen_phase(30);
    foreach (COLUMN_PLAN[i]) begin
      settle();
      write_reg(REG_COLUMNS, COLUMN_PLAN[i]);
      write_reg(REG_LINES, LINE_PLAN[i]);
      if (i == $size(COLUMN_PLAN) - 1) quiet_tail = 1'b1;
      gen_phase(34);
    end
    settle();
    if (mismatches == 0) $display("All tests passed");
    else $display("Some tests failed");
    $finish;
  end

endmodule

FILE: context_huffman_frame_decoder_top.f
+incdir+sv
sv/ctxhf_pkg.sv
sv/context_huffman_frame_decoder_top.sv
dv/testbench.sv
